// ----- hw/rtl/lpht_pkg.sv -----
// Shared types and constants for the linear-probe hash table.
// Used by lpht_ctrl, lpht_dp and linear_probe_hash_table; depends on nothing.
`default_nettype none

package lpht_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned KEY_BITS    = 31;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned FV_BITS     = 32;
  localparam int unsigned OCC_BITS    = 7;

  // Request kinds; the fourth code is unused and answers as a miss
  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } lpht_op_t;

  // Result codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } lpht_status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mod_step;
    logic probe_issue;
    logic probe_step;
    logic commit;
    logic clear_step;
  } lpht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_last;
    logic probe_stop;
    logic clear_last;
  } lpht_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lpht_ctrl.sv -----
// Sequencer for the hash table: clear sweep, home-slot reduction, probe walk.
// Depends on lpht_pkg.
`default_nettype none

module lpht_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output lpht_pkg::lpht_cmd_t    cmd,
  input  wire lpht_pkg::lpht_sts_t sts
);

  import lpht_pkg::*;

  // power-of-two depth takes the home slot straight from the low key bits
  localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ISSUE,
    S_PROBE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = POW2 ? S_ISSUE : S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.probe_issue = 1'b1;
        state_nxt       = S_PROBE;
      end
      S_PROBE: begin
        if (sts.probe_stop) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lpht_dp.sv -----
// Datapath for the hash table: request registers, reciprocal key reduction,
// probe address walk, slot RAM and result registers. Depends on lpht_pkg, lpht_ram.
`default_nettype none

module lpht_dp #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire lpht_pkg::lpht_cmd_t                  cmd,
  output lpht_pkg::lpht_sts_t                       sts,
  input  wire logic [lpht_pkg::OP_BITS-1:0]         in_op,
  input  wire logic [lpht_pkg::KEY_BITS-1:0]        in_key,
  input  wire logic [VALUE_BITS-1:0]                in_value,
  output logic      [lpht_pkg::STATUS_BITS-1:0]     out_status,
  output logic      [lpht_pkg::FV_BITS-1:0]         out_found_value,
  output logic      [lpht_pkg::OCC_BITS-1:0]        out_occupancy
);

  import lpht_pkg::*;

  localparam bit          POW2   = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW     = 2 + KEY_BITS + VALUE_BITS;
  // slot word layout: occupied, removed, key, value
  localparam int unsigned OCC_B  = EW - 1;
  localparam int unsigned RMV_B  = EW - 2;
  localparam int unsigned KEY_HI = EW - 3;
  // floor(2^KEY_BITS / depth): quotient estimate is at most one low
  localparam logic [KEY_BITS-1:0] RECIP = KEY_BITS'((64'd1 << KEY_BITS) / TABLE_DEPTH);

  // request registers
  logic [OP_BITS-1:0]    op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // key reduction
  logic                  mod_cnt_r;
  logic [KEY_BITS-1:0]   quo_r;
  logic [2*KEY_BITS-1:0] prod;
  logic [AW:0]           qd_lo;
  logic [AW-1:0]         rem_r, rem_nxt;
  logic [AW:0]           rem_t;

  // probe walk and occupancy
  logic [AW-1:0]         chk_addr_r, addr_inc;
  logic [CW-1:0]         vis_r;
  logic [CW-1:0]         count_r;

  // result registers
  lpht_status_t          status_r;
  logic [FV_BITS-1:0]    fv_r;
  logic [OCC_BITS-1:0]   occ_r;

  // RAM signals
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;

  // decoded slot and commit decision
  logic                  s_occ, s_rmv, key_eq, live;
  logic [KEY_BITS-1:0]   s_key;
  logic [VALUE_BITS-1:0] s_val;
  logic                  wr_en, cnt_up;
  logic [EW-1:0]         wr_word;
  lpht_status_t          status_c;
  logic [FV_BITS-1:0]    fv_c;
  logic [CW-1:0]         count_c;

  // quotient estimate by reciprocal multiply, first reduction cycle
  assign prod = (2*KEY_BITS)'(key_r) * (2*KEY_BITS)'(RECIP);

  // remainder from the low bits, then one correcting subtract
  assign qd_lo = quo_r[AW:0] * (AW+1)'(TABLE_DEPTH);

  always_comb begin
    rem_t = key_r[AW:0] - qd_lo;
    if (rem_t >= (AW+1)'(TABLE_DEPTH)) begin
      rem_t = rem_t - (AW+1)'(TABLE_DEPTH);
    end
    rem_nxt = rem_t[AW-1:0];
  end

  assign addr_inc = (chk_addr_r == AW'(TABLE_DEPTH - 1)) ? '0 : chk_addr_r + 1'b1;

  // slot fields
  assign s_occ  = ram_rdata[OCC_B];
  assign s_rmv  = ram_rdata[RMV_B];
  assign s_key  = ram_rdata[KEY_HI -: KEY_BITS];
  assign s_val  = ram_rdata[VALUE_BITS-1:0];
  assign key_eq = s_occ && (s_key == key_r);
  assign live   = key_eq && !s_rmv;

  // status to controller
  assign sts.mod_last   = mod_cnt_r;
  assign sts.probe_stop = !s_occ || key_eq || (vis_r == CW'(TABLE_DEPTH));
  assign sts.clear_last = (chk_addr_r == AW'(TABLE_DEPTH - 1));

  // outcome of the request at the slot where the probe stopped
  always_comb begin
    wr_en    = 1'b0;
    cnt_up   = 1'b0;
    wr_word  = {1'b1, 1'b0, key_r, val_r};
    status_c = ST_MISS;
    fv_c     = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (!s_occ) begin
          wr_en    = 1'b1;
          cnt_up   = 1'b1;
          status_c = ST_DONE;
        end else if (key_eq) begin
          if (s_rmv) begin
            wr_en    = 1'b1;
            status_c = ST_DONE;
          end else begin
            status_c = ST_HIT;
          end
        end else begin
          status_c = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (live) begin
          wr_en    = 1'b1;
          wr_word  = {1'b1, 1'b1, s_key, s_val};
          status_c = ST_DONE;
        end
      end
      OP_FIND: begin
        if (live) begin
          status_c = ST_HIT;
          fv_c     = FV_BITS'(s_val);
        end
      end
      default: begin
        status_c = ST_MISS;
      end
    endcase
    count_c = count_r + CW'(cnt_up);
  end

  // RAM ports: clear sweep writes zeros, commit writes at the stopping slot
  assign ram_we    = cmd.clear_step || (cmd.commit && wr_en);
  assign ram_wdata = cmd.clear_step ? '0 : wr_word;
  assign ram_raddr = cmd.probe_issue ? rem_r : addr_inc;

  lpht_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_addr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request capture and key reduction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      key_r     <= in_key;
      val_r     <= in_value;
      mod_cnt_r <= 1'b0;
      rem_r     <= POW2 ? in_key[AW-1:0] : '0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= 1'b1;
      quo_r     <= prod[2*KEY_BITS-1:KEY_BITS];
      rem_r     <= rem_nxt;
    end
  end

  // probe walk; the same address register sweeps the RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_addr_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.probe_issue) begin
        chk_addr_r <= rem_r;
      end else if (cmd.probe_step || cmd.clear_step) begin
        chk_addr_r <= addr_inc;
      end
      if (cmd.commit) begin
        count_r <= count_c;
      end
    end
  end

  // visited-slot count
  always_ff @(posedge clk) begin
    if (cmd.probe_issue) begin
      vis_r <= CW'(1);
    end else if (cmd.probe_step) begin
      vis_r <= vis_r + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_c;
      fv_r     <= fv_c;
      occ_r    <= OCC_BITS'(count_c);
    end
  end

  assign out_status      = status_r;
  assign out_found_value = fv_r;
  assign out_occupancy   = occ_r;

endmodule

`default_nettype wire

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Hash table with open addressing and linear probing: insert, remove, find.
// The result strobe follows start once the probe walk has visited between 1 and
// TABLE_DEPTH slots, after a reciprocal key reduction when the depth is not a
// power of two. busy drops with the strobe; no new request is taken before then.
// The probe walk reads one slot per cycle from the slot RAM.
// Reset: a clearing sweep (busy high) empties all slots.
`default_nettype none

module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = lpht_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [lpht_pkg::OP_BITS-1:0]         in_op,
  input  wire logic [lpht_pkg::KEY_BITS-1:0]        in_key,
  input  wire logic [VALUE_BITS-1:0]                in_value,
  output logic                                      out_valid,
  output logic      [lpht_pkg::STATUS_BITS-1:0]     out_status,
  output logic      [lpht_pkg::FV_BITS-1:0]         out_found_value,
  output logic      [lpht_pkg::OCC_BITS-1:0]        out_occupancy
);

  import lpht_pkg::*;

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // sequencer
  lpht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath and slot storage
  lpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_occupancy   (out_occupancy)
  );

endmodule

`default_nettype wire
